// ----- design/btff_pkg.sv -----
// ----------------------------------------------------------------------------
// btff_pkg
// Shared types and constants for the boundary-tag first-fit allocator.
// ----------------------------------------------------------------------------
package btff_pkg;

	localparam int ARENA_BYTES_DEF = 1048576;
	localparam int TAG_BYTES       = 16;
	localparam int MIN_SPLIT_UNITS = 3;

	localparam int OFF_W   = 20;
	localparam int SIZE_W  = 32;
	localparam int BYTES_W = 21;
	localparam int BLOCK_W = 16;

	localparam logic [2:0] ST_INPLACE = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_MOVED   = 3'd2;
	localparam logic [2:0] ST_FREED   = 3'd3;
	localparam logic [2:0] ST_NOSPACE = 3'd4;
	localparam logic [2:0] ST_BIG     = 3'd5;
	localparam logic [2:0] ST_BADOFF  = 3'd6;

	typedef struct packed {
		logic               has_old;
		logic [OFF_W-1:0]   old_offset;
		logic [SIZE_W-1:0]  new_size;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [OFF_W-1:0]   result_offset;
		logic [BYTES_W-1:0] move_len;
		logic [BYTES_W-1:0] used_bytes;
		logic [BLOCK_W-1:0] used_blocks;
	} rsp_t;

endpackage

// ----- design/btff_ram.sv -----
// ----------------------------------------------------------------------------
// btff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module btff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/boundary_tag_first_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// Arena allocator with header/footer tags held in one tag RAM; first-fit
// allocation, split, in-place resize and coalescing on free.
// ----------------------------------------------------------------------------
//  channel   signals            transfer
//  request   start, busy, req   start && !busy
//  result    done, rsp          done, one cycle, cannot be held off
//
// Accepted requests walk the block chain from slot 0, one tag RAM read per
// cycle, then write tags one per cycle. Busy covers the walk plus the tag
// updates, longest for a move (grow check, split, release and coalesce);
// requests rejected at accept go straight to S_EMIT. done strobes in the
// first cycle busy is low; the receiver cannot stall it. After reset the
// states S_INIT0 and S_INIT1 write the initial arena tags with busy high.
module boundary_tag_first_fit_allocator #(
	parameter int ARENA_BYTES = btff_pkg::ARENA_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  btff_pkg::req_t  req,
	output logic            done,
	output btff_pkg::rsp_t  rsp
);
	import btff_pkg::*;

	localparam int SLOTS = ARENA_BYTES / TAG_BYTES;
	localparam int SW    = $clog2(SLOTS);
	localparam int PW    = SW + 2;
	localparam int TW    = SW + 1;
	localparam int NW    = $clog2(ARENA_BYTES + 1);

	typedef enum logic [4:0] {
		S_INIT0, S_INIT1, S_IDLE, S_LV, S_FF, S_WH, S_WF, S_SPA, S_SPB,
		S_TM0, S_TM1, S_G0, S_G1, S_F0, S_F1, S_F2, S_F3, S_F4,
		S_PALLOC, S_PRES, S_PMOVE, S_EMIT
	} state_t;

	state_t              state_q, ret_q, sret_q;
	logic [PW-1:0]       cur_q, want_q, wb_q;
	logic [SW-1:0]       h_q, uh_q, cs_q, sb_q, tot_q, nu_q, wu_q, a_q;
	logic                wf_q, tm_q, mv_q, free_q;
	logic [NW-1:0]       nsz_q;
	logic [OFF_W-1:0]    off_q, res_q;
	logic [BYTES_W-1:0]  copy_q, lb_q;
	logic [BLOCK_W-1:0]  lk_q;
	logic [2:0]          st_q;
	logic                done_q;
	rsp_t                rsp_q;

	logic                we;
	logic [SW-1:0]       waddr, raddr;
	logic [TW-1:0]       wdata, rdata;
	logic [SW-1:0]       tag_u;
	logic                tag_f;
	logic [PW-1:0]       nxt, nx_h, nx_t, fpos, rem, merged;
	logic                sz0, big, hs_ok;
	logic [31:0]         hs;
	logic [SIZE_W:0]     ob, nsz_x;

	btff_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tags (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign tag_u  = rdata[TW-1:1];
	assign tag_f  = rdata[0];
	assign nxt    = cur_q + PW'(2) + PW'(tag_u);
	assign nx_h   = PW'(h_q) + PW'(2) + PW'(uh_q);
	assign nx_t   = PW'(sb_q) + PW'(2) + PW'(tot_q);
	assign fpos   = wb_q + PW'(1) + PW'(wu_q);
	assign rem    = PW'(tot_q) - want_q;
	assign merged = PW'(uh_q) + PW'(2) + PW'(tag_u);

	assign sz0   = (req.new_size == '0);
	assign big   = (req.new_size > SIZE_W'(ARENA_BYTES));
	assign hs    = 32'(req.old_offset[OFF_W-1:4]) - 32'd1;
	assign hs_ok = req.has_old && (req.old_offset[3:0] == 4'd0) &&
		(req.old_offset[OFF_W-1:4] != '0) && (hs < 32'(SLOTS));

	assign ob    = (SIZE_W+1)'({uh_q, 4'b0});
	assign nsz_x = (SIZE_W+1)'(nsz_q);

	always_comb begin
		case (state_q)
			S_LV, S_FF: raddr = SW'(nxt);
			S_F1, S_G0: raddr = SW'(nx_h);
			S_TM0:      raddr = SW'(nx_t);
			S_F3:       raddr = h_q - SW'(1);
			default:    raddr = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = SW'(wb_q);
		wdata = {wu_q, wf_q};
		case (state_q)
			S_INIT0: begin
				we    = 1'b1;
				waddr = '0;
				wdata = {SW'(SLOTS - 2), 1'b1};
			end
			S_INIT1: begin
				we    = 1'b1;
				waddr = SW'(SLOTS - 1);
				wdata = {SW'(SLOTS - 2), 1'b1};
			end
			S_WH: we = (wb_q < PW'(SLOTS));
			S_WF: begin
				we    = (fpos < PW'(SLOTS));
				waddr = SW'(fpos);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
			done_q  <= 1'b0;
			lb_q    <= '0;
			lk_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_IDLE;
				S_IDLE: if (start) begin
					off_q  <= req.old_offset;
					nsz_q  <= NW'(req.new_size);
					want_q <= PW'(({1'b0, req.new_size} + 33'd15) >> 4);
					h_q    <= SW'(hs);
					free_q <= sz0;
					res_q  <= '0;
					copy_q <= '0;
					cur_q  <= '0;
					mv_q   <= 1'b0;
					if (sz0 && !req.has_old) begin
						st_q    <= ST_FREED;
						state_q <= S_EMIT;
					end else if (!sz0 && big) begin
						st_q    <= ST_BIG;
						state_q <= S_EMIT;
					end else if (req.has_old) begin
						if (!hs_ok) begin
							st_q    <= ST_BADOFF;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_LV;
						end
					end else begin
						state_q <= S_FF;
					end
				end
				S_LV: begin
					if (cur_q == PW'(h_q)) begin
						uh_q <= tag_u;
						cs_q <= tag_u;
						if (tag_f) begin
							st_q    <= ST_BADOFF;
							state_q <= S_EMIT;
						end else if (free_q) begin
							lb_q    <= lb_q - BYTES_W'({tag_u, 4'b0});
							lk_q    <= lk_q - BLOCK_W'(1);
							st_q    <= ST_FREED;
							state_q <= S_F0;
						end else if (want_q <= PW'(tag_u)) begin
							if (PW'(tag_u) - want_q >= PW'(MIN_SPLIT_UNITS)) begin
								sb_q    <= h_q;
								tot_q   <= tag_u;
								tm_q    <= 1'b1;
								sret_q  <= S_PRES;
								state_q <= S_SPA;
							end else begin
								nu_q    <= tag_u;
								state_q <= S_PRES;
							end
						end else begin
							state_q <= S_G0;
						end
					end else if (nxt >= PW'(SLOTS) || nxt > PW'(h_q)) begin
						st_q    <= ST_BADOFF;
						state_q <= S_EMIT;
					end else begin
						cur_q <= nxt;
					end
				end
				S_FF: begin
					if (tag_f && PW'(tag_u) >= want_q) begin
						a_q     <= SW'(cur_q);
						sb_q    <= SW'(cur_q);
						tot_q   <= tag_u;
						tm_q    <= 1'b0;
						sret_q  <= mv_q ? S_PMOVE : S_PALLOC;
						state_q <= S_SPA;
					end else if (nxt >= PW'(SLOTS)) begin
						st_q    <= ST_NOSPACE;
						state_q <= S_EMIT;
					end else begin
						cur_q <= nxt;
					end
				end
				// split: allocated head, free tail when big enough
				S_SPA: begin
					wb_q    <= PW'(sb_q);
					wf_q    <= 1'b0;
					state_q <= S_WH;
					if (rem >= PW'(MIN_SPLIT_UNITS)) begin
						wu_q  <= SW'(want_q);
						nu_q  <= SW'(want_q);
						ret_q <= S_SPB;
					end else begin
						wu_q  <= tot_q;
						nu_q  <= tot_q;
						ret_q <= sret_q;
					end
				end
				S_SPB: begin
					wb_q    <= PW'(sb_q) + PW'(2) + want_q;
					wu_q    <= SW'(rem - PW'(2));
					wf_q    <= 1'b1;
					ret_q   <= tm_q ? S_TM0 : sret_q;
					state_q <= S_WH;
				end
				S_TM0: state_q <= S_TM1;
				S_TM1: begin
					if (nx_t < PW'(SLOTS) && tag_f) begin
						wb_q    <= PW'(sb_q) + PW'(2) + want_q;
						wu_q    <= SW'(rem + PW'(tag_u));
						wf_q    <= 1'b1;
						ret_q   <= sret_q;
						state_q <= S_WH;
					end else begin
						state_q <= sret_q;
					end
				end
				S_G0: state_q <= S_G1;
				S_G1: begin
					if (nx_h < PW'(SLOTS) && tag_f && merged >= want_q) begin
						sb_q    <= h_q;
						tot_q   <= SW'(merged);
						tm_q    <= 1'b0;
						sret_q  <= S_PRES;
						state_q <= S_SPA;
					end else begin
						mv_q    <= 1'b1;
						cur_q   <= '0;
						state_q <= S_FF;
					end
				end
				S_WH: state_q <= S_WF;
				S_WF: state_q <= ret_q;
				S_PRES: begin
					lb_q    <= lb_q - BYTES_W'({uh_q, 4'b0}) + BYTES_W'({nu_q, 4'b0});
					st_q    <= ST_INPLACE;
					res_q   <= off_q;
					state_q <= S_EMIT;
				end
				S_PALLOC: begin
					lb_q    <= lb_q + BYTES_W'({nu_q, 4'b0});
					lk_q    <= lk_q + BLOCK_W'(1);
					st_q    <= ST_NEW;
					res_q   <= OFF_W'({PW'(a_q) + PW'(1), 4'b0});
					state_q <= S_EMIT;
				end
				S_PMOVE: begin
					lb_q    <= lb_q - BYTES_W'({uh_q, 4'b0}) + BYTES_W'({nu_q, 4'b0});
					copy_q  <= BYTES_W'((ob < nsz_x) ? ob : nsz_x);
					st_q    <= ST_MOVED;
					res_q   <= OFF_W'({PW'(a_q) + PW'(1), 4'b0});
					state_q <= S_F0;
				end
				// release h, then coalesce right and left
				S_F0: begin
					wb_q    <= PW'(h_q);
					wu_q    <= uh_q;
					wf_q    <= 1'b1;
					ret_q   <= S_F1;
					state_q <= S_WH;
				end
				S_F1: state_q <= S_F2;
				S_F2: begin
					if (nx_h < PW'(SLOTS) && tag_f) begin
						cs_q    <= SW'(merged);
						wb_q    <= PW'(h_q);
						wu_q    <= SW'(merged);
						wf_q    <= 1'b1;
						ret_q   <= S_F3;
						state_q <= S_WH;
					end else begin
						state_q <= S_F3;
					end
				end
				S_F3: state_q <= (h_q != '0) ? S_F4 : S_EMIT;
				S_F4: begin
					if (tag_f && PW'(tag_u) + PW'(2) <= PW'(h_q)) begin
						wb_q    <= PW'(h_q) - PW'(2) - PW'(tag_u);
						wu_q    <= SW'(PW'(tag_u) + PW'(2) + PW'(cs_q));
						wf_q    <= 1'b1;
						ret_q   <= S_EMIT;
						state_q <= S_WH;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					done_q  <= 1'b1;
					rsp_q   <= '{status: st_q, result_offset: res_q, move_len: copy_q,
						used_bytes: lb_q, used_blocks: lk_q};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- design/btff_chk.sv -----
// ----------------------------------------------------------------------------
// btff_chk
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module btff_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input btff_pkg::rsp_t rsp
);
	import btff_pkg::*;

	// an accepted beat always keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accept not followed by busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");

	a_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_INPLACE && rsp.status != ST_NEW &&
		 rsp.status != ST_MOVED) |-> (rsp.result_offset == '0))
		else $error("offset on a status without block");

	a_copy_move: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_MOVED) |-> (rsp.move_len == '0))
		else $error("copy length without a move");

endmodule

bind boundary_tag_first_fit_allocator btff_chk u_btff_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
